@@ src/snt_pkg.sv @@
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types and constants for the sorted name table.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned NameBytes  = 8;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_POS  = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] name_key;
    logic [63:0] surname_text;
    logic [43:0] phone_bcd;
    logic [5:0]  delete_position;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  record_position;
    logic [63:0] found_name;
    logic [63:0] found_surname;
    logic [43:0] found_phone;
    logic        last_result;
  } rsp_t;

  typedef struct packed {
    logic [63:0] name;
    logic [63:0] surname;
    logic [43:0] phone;
  } rec_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_up;   // cells above pos take lower neighbour
    logic shift_down; // cells at or above pos take upper neighbour
    logic rotate;     // whole row rotates down by one (scan)
    logic write_new;  // cell at pos takes new record
    logic [IdxW-1:0] pos;
  } cell_ctl_t;

  function automatic logic [63:0] normalize_name(input logic [63:0] v);
    logic [63:0] res;
    logic        stop;
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b >= NameBytes || v[63-8*b -: 8] == 8'd0) stop = 1'b1;
      if (!stop) res[63-8*b -: 8] = v[63-8*b -: 8];
    end
    return res;
  endfunction

endpackage

@@ src/snt_cell.sv @@
// ----------------------------------------------------------------------------
// snt_cell
// One table slot: holds a record, shifts or rotates with its neighbours.
// ----------------------------------------------------------------------------
module snt_cell (
  input  logic              clk_i,
  input  logic [snt_pkg::IdxW-1:0] idx_i,
  input  snt_pkg::cell_ctl_t ctl_i,
  input  snt_pkg::rec_t     new_i,
  input  snt_pkg::rec_t     below_i,
  input  snt_pkg::rec_t     above_i,
  output snt_pkg::rec_t     rec_o
);
  import snt_pkg::*;

  rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.rotate) begin
      rec_d = above_i;
    end else if (ctl_i.write_new && idx_i == ctl_i.pos) begin
      rec_d = new_i;
    end else if (ctl_i.shift_up && idx_i > ctl_i.pos) begin
      rec_d = below_i;
    end else if (ctl_i.shift_down && idx_i >= ctl_i.pos) begin
      rec_d = above_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

@@ src/sorted_name_table.sv @@
// ----------------------------------------------------------------------------
// sorted_name_table
// Sorted record table built as a row of cells with a small sequencer.
//
// Requests arrive on req_valid_i/req_stall_o carrying req_i; results leave
// on rsp_valid_o/rsp_stall_i carrying rsp_o. A request is taken while the
// block is idle and its output is free. Every request first makes one full
// rotation of the cell row, during which cell 0 is examined at each step:
// the insert slot is counted, the record to delete is captured, and
// search/list results are produced in table order. S_APPLY then applies
// the shift for insert or delete, and S_DONE issues the last result.
// Search and list hold each hit back until the next hit or the end of the
// scan shows whether it is the last, so the rotation pauses while a held
// hit goes out ahead of the next; it also pauses while a result waits on a
// stalled receiver. Bad requests (empty insert name, full table, bad
// position) are answered from S_IDLE without a scan. Reset empties the
// table (count zero) and clears the output valid; record contents are not
// cleared.
// ----------------------------------------------------------------------------
module sorted_name_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  snt_pkg::req_t  req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output snt_pkg::rsp_t  rsp_o
);
  import snt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] step_q, step_d;   // rotation step = index of cell 0 record
  logic [CntW-1:0] ins_q, ins_d;
  logic            hit_q, hit_d;
  logic [1:0]      op_q;
  logic [63:0]     key_q;
  rec_t            new_q;
  logic [IdxW-1:0] del_q;
  rsp_t            rsp_q, rsp_d;
  logic            rv_q, rv_d;

  cell_ctl_t ctl;
  rec_t      recs [TableDepth];

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    snt_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IdxW'(g)),
      .ctl_i  (ctl),
      .new_i  (new_q),
      .below_i(recs[(g + TableDepth - 1) % TableDepth]),
      .above_i(recs[(g + 1) % TableDepth]),
      .rec_o  (recs[g])
    );
  end

  logic out_free, accept, last_step, in_range, match;
  logic [63:0] nkey;

  assign out_free    = !rv_q || !rsp_stall_i;
  assign req_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept      = req_valid_i && !req_stall_o;
  assign nkey        = normalize_name(req_i.name_key);
  assign last_step   = step_q == CntW'(TableDepth - 1);
  assign in_range    = step_q < count_q;
  assign match       = in_range && (op_q == OP_LIST || recs[0].name == key_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    step_d  = step_q;
    ins_d   = ins_q;
    hit_d   = hit_q;
    rsp_d   = rsp_q;
    rv_d    = rv_q && rsp_stall_i;
    ctl     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          step_d = '0;
          ins_d  = '0;
          hit_d  = 1'b0;
          state_d = S_SCAN;
          rsp_d  = '0;
          if (req_i.opcode == OP_INSERT && nkey == '0) begin
            rsp_d.status = ST_EMPTY; rsp_d.last_result = 1'b1; rv_d = 1'b1;
            state_d = S_IDLE;
          end else if (req_i.opcode == OP_INSERT && count_q == CntW'(TableDepth)) begin
            rsp_d.status = ST_FULL; rsp_d.last_result = 1'b1; rv_d = 1'b1;
            state_d = S_IDLE;
          end else if (req_i.opcode == OP_DELETE &&
                       (req_i.delete_position == '0 ||
                        7'(req_i.delete_position) > 7'(count_q))) begin
            rsp_d.status = ST_BAD_POS; rsp_d.last_result = 1'b1; rv_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if ((op_q == OP_SEARCH || op_q == OP_LIST) && match && hit_q && !rv_q) begin
            // another hit follows, so the held one goes out first
            rv_d = 1'b1;
          end else begin
            ctl.rotate = 1'b1;
            step_d = step_q + 1'b1;
            if (op_q == OP_INSERT && in_range && recs[0].name <= key_q)
              ins_d = ins_q + 1'b1;
            if (op_q == OP_DELETE && step_q[IdxW-1:0] == del_q) begin
              rsp_d.status          = ST_OK;
              rsp_d.record_position = 6'(step_q + 1'b1);
              rsp_d.found_name      = recs[0].name;
              rsp_d.found_surname   = recs[0].surname;
              rsp_d.found_phone     = recs[0].phone;
              rsp_d.last_result     = 1'b1;
            end
            if ((op_q == OP_SEARCH || op_q == OP_LIST) && match) begin
              // hold the hit back until we know whether it is last
              rsp_d.status          = ST_OK;
              rsp_d.record_position = 6'(step_q + 1'b1);
              rsp_d.found_name      = recs[0].name;
              rsp_d.found_surname   = recs[0].surname;
              rsp_d.found_phone     = recs[0].phone;
              rsp_d.last_result     = 1'b0;
              hit_d = 1'b1;
            end
            if (last_step) state_d = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        if (op_q == OP_INSERT) begin
          ctl.shift_up  = 1'b1;
          ctl.write_new = 1'b1;
          ctl.pos       = ins_q[IdxW-1:0];
          count_d       = count_q + 1'b1;
        end else if (op_q == OP_DELETE) begin
          ctl.shift_down = 1'b1;
          ctl.pos        = del_q;
          count_d        = count_q - 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          rv_d = 1'b1;
          state_d = S_IDLE;
          if (op_q == OP_INSERT) begin
            rsp_d.status          = ST_OK;
            rsp_d.record_position = 6'(ins_q + 1'b1);
            rsp_d.found_name      = new_q.name;
            rsp_d.found_surname   = new_q.surname;
            rsp_d.found_phone     = new_q.phone;
            rsp_d.last_result     = 1'b1;
          end else if (op_q != OP_DELETE) begin
            rsp_d.last_result = 1'b1;
            if (!hit_q) rsp_d = '{status: ST_NO_MATCH, last_result: 1'b1, default: '0};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
      step_q  <= '0;
      ins_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      step_q  <= step_d;
      ins_q   <= ins_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      op_q  <= req_i.opcode;
      key_q <= nkey;
      new_q <= '{name: nkey, surname: req_i.surname_text, phone: req_i.phone_bcd};
      del_q <= IdxW'(req_i.delete_position - 6'd1);
    end
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("count overflow");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && rsp_stall_i |=> rv_q && $stable(rsp_q)) else $error("result dropped");
  a_apply_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |=> state_q == S_DONE) else $error("apply sequencing");
  a_idle_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == S_IDLE) else $error("accept while busy");

endmodule
